@@ sv/cartridge_bank_mapper_irq_core_defines.svh @@
// Assertion macros used by the cartridge bank mapper core.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define CBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define CBM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CBM_ASSERT(lbl, prop, msg)
`define CBM_NEVER(lbl, cond, msg)
`endif

`endif

@@ sv/cbm_pkg.sv @@
// Types and constants of the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_LINE  = 2'd1,
        REQ_CYCLE = 2'd2
    } req_kind_t;

    localparam logic [3:0] PAGE_PRG_LO = 4'h8;
    localparam logic [3:0] PAGE_PRG_HI = 4'hA;
    localparam logic [3:0] PAGE_CHR_LO = 4'hB;
    localparam logic [3:0] PAGE_CHR_HI = 4'hE;
    localparam logic [3:0] PAGE_IRQ    = 4'hF;

    // Register select on address bits 3:2 within the IRQ page.
    localparam logic [1:0] IRQ_SEL_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_SEL_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_SEL_MODE     = 2'd2;
    localparam logic [1:0] IRQ_SEL_ACK      = 2'd3;

    localparam logic [8:0] PRESCALE_PERIOD = 9'h072;
    localparam logic [8:0] PRESCALE_MAX    = 9'h1FF;
    localparam logic [8:0] PRESCALE_LIMIT  = PRESCALE_MAX - PRESCALE_PERIOD;
    localparam logic [7:0] COUNT_TOP       = 8'hFF;
    localparam logic [1:0] MODE_BOTH       = 2'b11;
    localparam logic [1:0] MODE_OFF        = 2'b00;
    localparam int unsigned CHR_BANKS      = 8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
        logic [7:0]  cycle_count;
    } req_t;

    typedef struct packed {
        logic [7:0] prg_bank_lo;
        logic [7:0] prg_bank_hi;
        logic [7:0] chr_bank_0;
        logic [7:0] chr_bank_1;
        logic [7:0] chr_bank_2;
        logic [7:0] chr_bank_3;
        logic [7:0] chr_bank_4;
        logic [7:0] chr_bank_5;
        logic [7:0] chr_bank_6;
        logic [7:0] chr_bank_7;
        logic       irq_line;
    } res_t;

endpackage

@@ sv/cbm_if.sv @@
// Valid/ready channel interfaces for mapper requests and results.
`timescale 1ns / 1ps

interface cbm_req_if
    import cbm_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cbm_res_if
    import cbm_pkg::*;
();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/cartridge_bank_mapper_irq_core.sv @@
// Cartridge bank mapper with scanline and CPU-cycle IRQ counter.
//
// Channel req carries one word per request: a CPU register write, a scanline
// tick or a CPU-cycle tick. Channel res returns one word per request with the
// two switchable 8K program banks, the eight 1K character banks and the
// pending interrupt, all as they stand after that request.
// A request is captured in an input register, then decoded and applied to
// the mapper state once the result register can take it, which also loads
// the result register. The result is offered from that register, and one
// request is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds its word and the input
// register takes one further request; req.ready drops after that.
// Reset clears both pipeline registers and returns the mapper to program
// banks 0 and 1, character bank n in slot n, and the counter stopped with no
// interrupt pending. No request is lost across a stall.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_irq_core_defines.svh"

module cartridge_bank_mapper_irq_core
    import cbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cbm_req_if.sink   req,
    cbm_res_if.source res
);

    logic       s1_valid_reg;
    req_t       s1_req_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       s1_fire;

    logic [7:0] prg_lo_reg, prg_lo_next;
    logic [7:0] prg_hi_reg, prg_hi_next;
    logic [7:0] chr_reg [CHR_BANKS];
    logic [7:0] chr_next [CHR_BANKS];
    logic [7:0] reload_reg, reload_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] count_reg, count_next;
    logic [8:0] prescale_reg, prescale_next;
    logic       flag_reg, flag_next;

    logic [3:0] page;
    logic [1:0] sel;
    logic [3:0] nib;
    logic [3:0] chr_off;
    logic [2:0] chr_idx;
    logic [9:0] sum_wide;
    logic [8:0] sum_sat;
    logic       clock_cnt;
    res_t       res_next;

    // The input register advances when the result register is free or drains.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || s1_fire;

    assign page     = s1_req_reg.bus_addr[15:12];
    assign sel      = s1_req_reg.bus_addr[3:2];
    assign nib      = s1_req_reg.bus_data[3:0];
    assign chr_off  = page - PAGE_CHR_LO;
    assign chr_idx  = {chr_off[1:0], s1_req_reg.bus_addr[3]};
    assign sum_wide = {1'b0, prescale_reg} + {2'b00, s1_req_reg.cycle_count};
    assign sum_sat  = sum_wide[9] ? PRESCALE_MAX : sum_wide[8:0];

    always_comb
    begin
        prg_lo_next   = prg_lo_reg;
        prg_hi_next   = prg_hi_reg;
        chr_next      = chr_reg;
        reload_next   = reload_reg;
        mode_next     = mode_reg;
        count_next    = count_reg;
        prescale_next = prescale_reg;
        flag_next     = flag_reg;
        clock_cnt     = 1'b0;

        if (s1_fire)
        begin
            case (s1_req_reg.req_type)
                REQ_WRITE:
                begin
                    if (page == PAGE_PRG_LO)
                    begin
                        prg_lo_next = s1_req_reg.bus_data;
                    end
                    else if (page == PAGE_PRG_HI)
                    begin
                        prg_hi_next = s1_req_reg.bus_data;
                    end
                    else if (page inside {[PAGE_CHR_LO:PAGE_CHR_HI]})
                    begin
                        if (s1_req_reg.bus_addr[2])
                        begin
                            chr_next[chr_idx] = {nib, chr_reg[chr_idx][3:0]};
                        end
                        else
                        begin
                            chr_next[chr_idx] = {chr_reg[chr_idx][7:4], nib};
                        end
                    end
                    else if (page == PAGE_IRQ)
                    begin
                        flag_next = 1'b0;
                        case (sel)
                            IRQ_SEL_LATCH_LO: reload_next = {reload_reg[7:4], nib};
                            IRQ_SEL_LATCH_HI: reload_next = {nib, reload_reg[3:0]};
                            IRQ_SEL_MODE:
                            begin
                                mode_next = s1_req_reg.bus_data[1:0];
                                if (s1_req_reg.bus_data[1])
                                begin
                                    count_next    = reload_reg;
                                    prescale_next = '0;
                                end
                            end
                            IRQ_SEL_ACK: mode_next = mode_reg[0] ? MODE_BOTH : MODE_OFF;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                REQ_LINE:
                begin
                    clock_cnt = mode_reg[1];
                end
                REQ_CYCLE:
                begin
                    if (mode_reg[1])
                    begin
                        if (sum_sat >= PRESCALE_PERIOD)
                        begin
                            prescale_next = sum_sat - PRESCALE_PERIOD;
                            clock_cnt     = 1'b1;
                        end
                        else
                        begin
                            prescale_next = sum_sat;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Ticks and writes never coincide, so the counter step comes last.
            if (clock_cnt)
            begin
                if (count_reg == COUNT_TOP)
                begin
                    flag_next  = 1'b1;
                    count_next = reload_reg;
                    mode_next  = mode_reg[0] ? MODE_BOTH : MODE_OFF;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                end
            end
        end
    end

    always_comb
    begin
        res_next.prg_bank_lo = prg_lo_next;
        res_next.prg_bank_hi = prg_hi_next;
        res_next.chr_bank_0  = chr_next[0];
        res_next.chr_bank_1  = chr_next[1];
        res_next.chr_bank_2  = chr_next[2];
        res_next.chr_bank_3  = chr_next[3];
        res_next.chr_bank_4  = chr_next[4];
        res_next.chr_bank_5  = chr_next[5];
        res_next.chr_bank_6  = chr_next[6];
        res_next.chr_bank_7  = chr_next[7];
        res_next.irq_line    = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prg_lo_reg    <= 8'd0;
            prg_hi_reg    <= 8'd1;
            for (int i = 0; i < CHR_BANKS; i++)
            begin
                chr_reg[i] <= 8'(i);
            end
            reload_reg    <= '0;
            mode_reg      <= '0;
            count_reg     <= '0;
            prescale_reg  <= '0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            prg_lo_reg   <= prg_lo_next;
            prg_hi_reg   <= prg_hi_next;
            chr_reg      <= chr_next;
            reload_reg   <= reload_next;
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            flag_reg     <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_req_reg <= req.payload;
        end
        if (s1_fire)
        begin
            out_reg <= res_next;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    // A raised interrupt always comes from a tick that reloaded the counter.
    `CBM_ASSERT(a_irq_from_tick, $rose(flag_reg) |-> $past(s1_fire) && $past(s1_req_reg.req_type) != REQ_WRITE, "interrupt raised without a tick")
    `CBM_ASSERT(a_irq_reload, $rose(flag_reg) |-> count_reg == reload_reg, "counter not reloaded on overflow")
    `CBM_NEVER(a_prescale_range, prescale_reg > PRESCALE_LIMIT, "prescaler left its range")
    `CBM_ASSERT(a_state_hold, !$past(s1_fire) |-> $stable(count_reg) && $stable(prg_lo_reg) && $stable(flag_reg), "state changed with no word processed")
    `CBM_ASSERT(a_result_load, s1_fire |=> out_valid_reg && out_reg.irq_line == flag_reg, "result register out of step with state")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the cartridge bank mapper with its IRQ counter.
`timescale 1ns / 1ps

module tb_top;
    import cbm_pkg::*;

    localparam logic [1:0] REQ_SPARE     = 2'd3;
    localparam logic [3:0] PAGE_UNMAPPED = 4'h9;
    localparam int         N_DIRECTED    = 25;
    localparam int         PHASE_ITEMS   = 634;
    localparam int         CYCLE_LIMIT   = 200000;

    typedef struct packed {
        req_t       rq;
        logic       known;
        res_t       want;
    } stim_row_t;

    // Rows marked known carry the bank view typed in; the others are predicted.
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        {REQ_SPARE, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00, 8'h01, 64'h0001020304050607, 1'b0},
        {REQ_LINE,  16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h01, 64'h0001020304050607, 1'b0},
        {REQ_WRITE, 16'h8000, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'h01, 64'h0001020304050607, 1'b0},
        {REQ_WRITE, 16'hAFFF, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h00, 64'h0001020304050607, 1'b0},
        {REQ_WRITE, 16'h9000, 8'h55, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'h7FFF, 8'hAA, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'h0000, 8'hFF, 8'hFF, 1'b0, 81'd0},
        {REQ_WRITE, 16'hB000, 8'hFF, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hB004, 8'h0A, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hE00C, 8'hFF, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hE008, 8'hF0, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hCFF7, 8'h3C, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hF000, 8'hFE, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hF004, 8'hAF, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hF008, 8'h03, 8'h00, 1'b0, 81'd0},
        {REQ_LINE,  16'h0000, 8'h00, 8'h00, 1'b0, 81'd0},
        {REQ_LINE,  16'h0000, 8'h00, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hF00C, 8'h00, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hF008, 8'hFF, 8'h00, 1'b0, 81'd0},
        {REQ_CYCLE, 16'h0000, 8'h00, 8'hFF, 1'b0, 81'd0},
        {REQ_CYCLE, 16'h0000, 8'h00, 8'hFF, 1'b0, 81'd0},
        {REQ_CYCLE, 16'h0000, 8'h00, 8'hFF, 1'b0, 81'd0},
        {REQ_CYCLE, 16'h0000, 8'h00, 8'h00, 1'b0, 81'd0},
        {REQ_WRITE, 16'hF008, 8'h01, 8'h00, 1'b0, 81'd0},
        {REQ_CYCLE, 16'h0000, 8'h00, 8'hFF, 1'b0, 81'd0}
    };

    logic clk;
    logic rst_n;

    cbm_req_if req_ch ();
    cbm_res_if res_ch ();

    cartridge_bank_mapper_irq_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Mapper state as the predictor sees it.
    logic [7:0] m_prg_lo;
    logic [7:0] m_prg_hi;
    logic [7:0] m_chr [CHR_BANKS];
    logic [7:0] m_latch;
    logic [1:0] m_mode;
    logic [7:0] m_count;
    logic [8:0] m_prescale;
    logic       m_pending;

    res_t expected_banks [$];
    int   mismatches;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void clock_irq_counter();
        if (m_count == COUNT_TOP)
        begin
            m_pending = 1'b1;
            m_count   = m_latch;
            m_mode    = m_mode[0] ? MODE_BOTH : MODE_OFF;
        end
        else
        begin
            m_count = m_count + 8'd1;
        end
    endfunction

    function automatic res_t mapper_step(input req_t r);
        logic [3:0] page;
        logic [3:0] page_off;
        logic [2:0] slot;
        logic [9:0] sum;
        res_t       v;
        page     = r.bus_addr[15:12];
        page_off = page - PAGE_CHR_LO;
        slot     = {page_off[1:0], r.bus_addr[3]};
        case (r.req_type)
            REQ_WRITE:
            begin
                if (page == PAGE_PRG_LO)
                    m_prg_lo = r.bus_data;
                else if (page == PAGE_PRG_HI)
                    m_prg_hi = r.bus_data;
                else if (page >= PAGE_CHR_LO && page <= PAGE_CHR_HI)
                begin
                    if (r.bus_addr[2])
                        m_chr[slot][7:4] = r.bus_data[3:0];
                    else
                        m_chr[slot][3:0] = r.bus_data[3:0];
                end
                else if (page == PAGE_IRQ)
                begin
                    m_pending = 1'b0;
                    case (r.bus_addr[3:2])
                        IRQ_SEL_LATCH_LO: m_latch[3:0] = r.bus_data[3:0];
                        IRQ_SEL_LATCH_HI: m_latch[7:4] = r.bus_data[3:0];
                        IRQ_SEL_MODE:
                        begin
                            m_mode = r.bus_data[1:0];
                            if (m_mode[1])
                            begin
                                m_count    = m_latch;
                                m_prescale = '0;
                            end
                        end
                        default: m_mode = m_mode[0] ? MODE_BOTH : MODE_OFF;
                    endcase
                end
            end
            REQ_LINE:
            begin
                if (m_mode[1])
                    clock_irq_counter();
            end
            REQ_CYCLE:
            begin
                if (m_mode[1])
                begin
                    // The sum saturates before the period is taken off, once.
                    sum = {1'b0, m_prescale} + {2'b00, r.cycle_count};
                    if (sum > {1'b0, PRESCALE_MAX})
                        sum = {1'b0, PRESCALE_MAX};
                    if (sum >= {1'b0, PRESCALE_PERIOD})
                    begin
                        sum = sum - {1'b0, PRESCALE_PERIOD};
                        clock_irq_counter();
                    end
                    m_prescale = sum[8:0];
                end
            end
            default: ;
        endcase
        v.prg_bank_lo = m_prg_lo;
        v.prg_bank_hi = m_prg_hi;
        v.chr_bank_0  = m_chr[0];
        v.chr_bank_1  = m_chr[1];
        v.chr_bank_2  = m_chr[2];
        v.chr_bank_3  = m_chr[3];
        v.chr_bank_4  = m_chr[4];
        v.chr_bank_5  = m_chr[5];
        v.chr_bank_6  = m_chr[6];
        v.chr_bank_7  = m_chr[7];
        v.irq_line    = m_pending;
        return v;
    endfunction

    // Random requests lean towards the IRQ page, an enabled counter and a
    // latch close to the top, so that overflows come often.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.req_type    = REQ_WRITE;
        r.bus_addr    = 16'($urandom_range(0, 16'hFFFF));
        r.bus_data    = 8'($urandom_range(0, 8'hFF));
        r.cycle_count = 8'($urandom_range(0, 8'hFF));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            case ($urandom_range(0, 9))
                0: ;
                1: r.bus_addr[15:12] = PAGE_PRG_LO;
                2: r.bus_addr[15:12] = PAGE_PRG_HI;
                3, 4: r.bus_addr[15:12] = PAGE_CHR_LO + 4'($urandom_range(0, 3));
                5, 6, 7, 8:
                begin
                    r.bus_addr[15:12] = PAGE_IRQ;
                    if (r.bus_addr[3:2] == IRQ_SEL_MODE && $urandom_range(0, 3) != 0)
                        r.bus_data[1] = 1'b1;
                    if (r.bus_addr[3:2] == IRQ_SEL_LATCH_HI && $urandom_range(0, 1) != 0)
                        r.bus_data[3:0] = 4'hF;
                end
                default:
                begin
                    if ($urandom_range(0, 1) != 0)
                        r.bus_addr[15:12] = PAGE_UNMAPPED;
                    else
                        r.bus_addr[15] = 1'b0;
                end
            endcase
        end
        else if (pick < 70)
            r.req_type = REQ_LINE;
        else if (pick < 95)
        begin
            r.req_type = REQ_CYCLE;
            if ($urandom_range(0, 2) == 0)
                r.cycle_count = 8'($urandom_range(0, 40));
        end
        else
            r.req_type = REQ_SPARE;
        return r;
    endfunction

    // Offers one word from a falling edge, records its bank view once taken,
    // and returns at the next falling edge.
    task automatic send_request(input req_t r, input logic known, input res_t want);
        res_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = mapper_step(r);
        expected_banks.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_banks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result word %h with nothing expected",
                             $realtime, res_ch.payload);
            end
            else
            begin
                want = expected_banks.pop_front();
                check_field("prg_bank_lo", res_ch.payload.prg_bank_lo, want.prg_bank_lo);
                check_field("prg_bank_hi", res_ch.payload.prg_bank_hi, want.prg_bank_hi);
                check_field("chr_bank_0", res_ch.payload.chr_bank_0, want.chr_bank_0);
                check_field("chr_bank_1", res_ch.payload.chr_bank_1, want.chr_bank_1);
                check_field("chr_bank_2", res_ch.payload.chr_bank_2, want.chr_bank_2);
                check_field("chr_bank_3", res_ch.payload.chr_bank_3, want.chr_bank_3);
                check_field("chr_bank_4", res_ch.payload.chr_bank_4, want.chr_bank_4);
                check_field("chr_bank_5", res_ch.payload.chr_bank_5, want.chr_bank_5);
                check_field("chr_bank_6", res_ch.payload.chr_bank_6, want.chr_bank_6);
                check_field("chr_bank_7", res_ch.payload.chr_bank_7, want.chr_bank_7);
                check_field("irq_line", {7'd0, res_ch.payload.irq_line},
                            {7'd0, want.irq_line});
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        res_ch.ready   = 1'b0;
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 32;
        recv_stall_pct = 76;
        m_prg_lo       = 8'd0;
        m_prg_hi       = 8'd1;
        m_latch        = 8'd0;
        m_mode         = MODE_OFF;
        m_count        = 8'd0;
        m_prescale     = 9'd0;
        m_pending      = 1'b0;
        for (int s = 0; s < CHR_BANKS; s++)
            m_chr[s] = 8'(s);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED[i].rq, DIRECTED[i].known, DIRECTED[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                // Let the pipeline drain completely before the idling swaps.
                while (expected_banks.size() != 0)
                begin
                    req_ch.valid <= 1'b0;
                    @(negedge clk);
                end
                send_idle_pct  = 76;
                recv_stall_pct = 32;
            end
            else if (phase == 2)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (expected_banks.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatches == 0 && expected_banks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
